// ----- src/polygon_area_and_bounds_macros.svh -----
// Assertion macros used by the polygon area and bounds checker.
`ifndef POLYGON_AREA_AND_BOUNDS_MACROS_SVH
`define POLYGON_AREA_AND_BOUNDS_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define PAB_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a condition implies another in the same cycle.
`define PAB_ASSERT_IMPL(label, pre, post, msg) \
    `PAB_ASSERT_CLK(label, (pre) |-> (post), msg)

`endif

// ----- src/pab_pkg.sv -----
// Shared types and constants of the polygon area and bounds block.
package pab_pkg;

    localparam int IN_W       = 30;
    localparam int AREA_W     = 62;
    localparam int SUM_W      = 64;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 184;
    localparam int OUT_PAD_W  = OUT_DATA_W - AREA_W - 4 * IN_W;
    localparam int STEP_W     = 10;

    // round_digits codes: decimal places of metres kept
    localparam logic [1:0] DIG_M  = 2'd0;
    localparam logic [1:0] DIG_DM = 2'd1;
    localparam logic [1:0] DIG_CM = 2'd2;
    localparam logic [1:0] DIG_MM = 2'd3;

    typedef struct packed {
        logic ld_r;
        logic ld_b;
    } pab_rnd_ctrl_t;

    typedef struct packed {
        logic ld_c;
        logic ld_t;
        logic upd_sum;
        logic ld_d;
        logic b_last;
        logic c_last;
        logic t_last;
    } pab_acc_ctrl_t;

endpackage

// ----- src/polygon_area_and_bounds.sv -----
// Polygon area and bounds: shoelace doubled area and bounding box per polygon.
//
// Vertices enter on the s_ stream one word per vertex; s_tlast marks the
// final vertex of a polygon. Each coordinate is rounded half away from zero
// to the step chosen by round_digits (cfg_ channel, always ready), which is
// latched with each vertex as it is accepted.
// One result word leaves on the m_ stream per polygon, carrying the
// absolute doubled area and the bounding box of the rounded vertices.
// Throughput: one vertex per cycle while s_tready is high, sustained across polygons.
// The result of a final vertex passes the input register, reciprocal
// quotient, rounded coordinate, cross products, edge term, running total
// and output register before it shows on m_tvalid.
// When the receiver stalls, the output register holds its word; vertices
// that produce no result keep draining, and s_tready drops only once a
// final vertex has to wait behind the full total and output registers.
// Reset clears all pipeline valid bits and the polygon state, and sets
// round_digits to 3 (whole millimetres).
module polygon_area_and_bounds #(
    parameter int COORD_BITS = 30
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [pab_pkg::IN_DATA_W-1:0]      s_tdata,  // vertex_x, vertex_y, zero pad
    input  logic                               s_tlast,  // final_vertex
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [pab_pkg::OUT_DATA_W-1:0]     m_tdata,  // area_doubled, bound_min_x,
                                                         // bound_max_x, bound_min_y,
                                                         // bound_max_y, zero pad
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [1:0]                         cfg_data  // round_digits
);
    import pab_pkg::*;

    localparam logic [SUM_W-1:0] AREA_CAP = SUM_W'(1) << (2 * COORD_BITS + 1);

    logic [1:0]               digits_reg;

    // stage valid and last flags
    logic a_v_reg, r_v_reg, b_v_reg, c_v_reg, t_v_reg, d_v_reg, e_v_reg;
    logic a_last_reg, r_last_reg, b_last_reg, c_last_reg, t_last_reg;

    logic [IN_W-1:0]          a_x_reg;
    logic [IN_W-1:0]          a_y_reg;
    logic [1:0]               a_dig_reg;

    logic accept;
    logic rdy_e, rdy_d, rdy_t, rdy_c, rdy_b, rdy_r;
    logic mv_a, mv_r, mv_b, mv_c, mv_t, mv_d;

    pab_rnd_ctrl_t            rnd_ctrl;
    pab_acc_ctrl_t            acc_ctrl;

    logic signed [COORD_BITS-1:0] rx;
    logic signed [COORD_BITS-1:0] ry;
    logic [SUM_W-1:0]             total;
    logic signed [COORD_BITS-1:0] min_x, max_x, min_y, max_y;

    logic [SUM_W-1:0]         mag;
    logic [AREA_W-1:0]        area_next;
    logic [AREA_W-1:0]        e_area_reg;
    logic signed [IN_W-1:0]   e_min_x_reg;
    logic signed [IN_W-1:0]   e_max_x_reg;
    logic signed [IN_W-1:0]   e_min_y_reg;
    logic signed [IN_W-1:0]   e_max_y_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digits_reg <= DIG_MM;
        end
        else if (cfg_valid && cfg_ready)
        begin
            digits_reg <= cfg_data;
        end
    end

    // ready chain; a non-final vertex leaves at the term stage
    assign rdy_e = !e_v_reg || m_tready;
    assign mv_d  = d_v_reg && rdy_e;
    assign rdy_d = !d_v_reg || rdy_e;
    assign mv_t  = t_v_reg && (!t_last_reg || rdy_d);
    assign rdy_t = !t_v_reg || mv_t;
    assign mv_c  = c_v_reg && rdy_t;
    assign rdy_c = !c_v_reg || rdy_t;
    assign mv_b  = b_v_reg && rdy_c;
    assign rdy_b = !b_v_reg || rdy_c;
    assign mv_r  = r_v_reg && rdy_b;
    assign rdy_r = !r_v_reg || rdy_b;
    assign mv_a  = a_v_reg && rdy_r;

    assign s_tready = !a_v_reg || rdy_r;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg    <= 1'b0;
            r_v_reg    <= 1'b0;
            b_v_reg    <= 1'b0;
            c_v_reg    <= 1'b0;
            t_v_reg    <= 1'b0;
            d_v_reg    <= 1'b0;
            e_v_reg    <= 1'b0;
            a_last_reg <= 1'b0;
            r_last_reg <= 1'b0;
            b_last_reg <= 1'b0;
            c_last_reg <= 1'b0;
            t_last_reg <= 1'b0;
        end
        else
        begin
            a_v_reg <= accept || (a_v_reg && !mv_a);
            r_v_reg <= mv_a   || (r_v_reg && !mv_r);
            b_v_reg <= mv_r   || (b_v_reg && !mv_b);
            c_v_reg <= mv_b   || (c_v_reg && !mv_c);
            t_v_reg <= mv_c   || (t_v_reg && !mv_t);
            d_v_reg <= (mv_t && t_last_reg) || (d_v_reg && !mv_d);
            e_v_reg <= mv_d   || (e_v_reg && !m_tready);
            if (accept)
            begin
                a_last_reg <= s_tlast;
            end
            if (mv_a)
            begin
                r_last_reg <= a_last_reg;
            end
            if (mv_r)
            begin
                b_last_reg <= r_last_reg;
            end
            if (mv_b)
            begin
                c_last_reg <= b_last_reg;
            end
            if (mv_c)
            begin
                t_last_reg <= c_last_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_x_reg   <= s_tdata[IN_W-1:0];
            a_y_reg   <= s_tdata[2*IN_W-1:IN_W];
            a_dig_reg <= digits_reg;
        end
    end

    assign rnd_ctrl.ld_r = mv_a;
    assign rnd_ctrl.ld_b = mv_r;

    pab_round #(
        .COORD_BITS (COORD_BITS)
    ) u_round_x (
        .clk     (clk),
        .ctrl    (rnd_ctrl),
        .coord   (a_x_reg),
        .digits  (a_dig_reg),
        .rounded (rx)
    );

    pab_round #(
        .COORD_BITS (COORD_BITS)
    ) u_round_y (
        .clk     (clk),
        .ctrl    (rnd_ctrl),
        .coord   (a_y_reg),
        .digits  (a_dig_reg),
        .rounded (ry)
    );

    assign acc_ctrl.ld_c    = mv_b;
    assign acc_ctrl.ld_t    = mv_c;
    assign acc_ctrl.upd_sum = mv_t;
    assign acc_ctrl.ld_d    = mv_t && t_last_reg;
    assign acc_ctrl.b_last  = b_last_reg;
    assign acc_ctrl.c_last  = c_last_reg;
    assign acc_ctrl.t_last  = t_last_reg;

    pab_accum #(
        .COORD_BITS (COORD_BITS)
    ) u_accum (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (acc_ctrl),
        .rx    (rx),
        .ry    (ry),
        .total (total),
        .min_x (min_x),
        .max_x (max_x),
        .min_y (min_y),
        .max_y (max_y)
    );

    // magnitude of the signed total, clamped at 2^(2*COORD_BITS+1)
    assign mag       = total[SUM_W-1] ? (~total + 1'b1) : total;
    assign area_next = (mag > AREA_CAP) ? AREA_CAP[AREA_W-1:0] : mag[AREA_W-1:0];

    always_ff @(posedge clk)
    begin
        if (mv_d)
        begin
            e_area_reg  <= area_next;
            e_min_x_reg <= IN_W'(min_x);
            e_max_x_reg <= IN_W'(max_x);
            e_min_y_reg <= IN_W'(min_y);
            e_max_y_reg <= IN_W'(max_y);
        end
    end

    assign m_tvalid = e_v_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, e_max_y_reg, e_min_y_reg,
                       e_max_x_reg, e_min_x_reg, e_area_reg};

endmodule

// ----- src/pab_round.sv -----
// Two-stage rounding of one coordinate to the selected decimal step.
module pab_round #(
    parameter int COORD_BITS = 30
) (
    input  logic                          clk,
    input  pab_pkg::pab_rnd_ctrl_t        ctrl,
    input  logic [pab_pkg::IN_W-1:0]      coord,
    input  logic [1:0]                    digits,
    output logic signed [COORD_BITS-1:0]  rounded
);
    import pab_pkg::*;

    localparam int MW = ((COORD_BITS > 10) ? COORD_BITS : 10) + 1;
    localparam int PW = 2 * MW + 1;
    // exact reciprocals for dividends below 2^MW
    localparam logic [MW:0] RCP_1000 = (MW + 1)'(((64'd1 << (MW + 10)) + 64'd999) / 64'd1000);
    localparam logic [MW:0] RCP_100  = (MW + 1)'(((64'd1 << (MW + 7)) + 64'd99) / 64'd100);
    localparam logic [MW:0] RCP_10   = (MW + 1)'(((64'd1 << (MW + 4)) + 64'd9) / 64'd10);
    localparam logic [MW-1:0] HALF_RANGE = MW'(1) << (COORD_BITS - 1);

    logic signed [COORD_BITS-1:0] v;
    logic signed [MW-1:0]         v_ext;
    logic [MW-1:0]                mag;
    logic [MW-1:0]                half;
    logic [MW:0]                  rcp;
    logic [MW-1:0]                mag_half;
    logic [PW-1:0]                prod;
    logic [MW-1:0]                q_next;

    logic [MW-1:0]                q_reg;
    logic                         neg_reg;
    logic [1:0]                   dig_reg;

    logic [STEP_W-1:0]            step;
    logic [MW+STEP_W-1:0]         rprod;
    logic [MW-1:0]                rmag;
    logic [MW-1:0]                lim;
    logic [MW-1:0]                sat;
    logic signed [COORD_BITS-1:0] rounded_next;
    logic signed [COORD_BITS-1:0] rounded_reg;

    assign v     = coord[COORD_BITS-1:0];
    assign v_ext = MW'(v);
    assign mag   = v[COORD_BITS-1] ? (~v_ext + 1'b1) : v_ext;

    always_comb
    begin
        case (digits)
            DIG_M:
            begin
                half = MW'(500);
                rcp  = RCP_1000;
            end
            DIG_DM:
            begin
                half = MW'(50);
                rcp  = RCP_100;
            end
            DIG_CM:
            begin
                half = MW'(5);
                rcp  = RCP_10;
            end
            default:
            begin
                half = '0;
                rcp  = '0;
            end
        endcase
    end

    assign mag_half = mag + half;
    assign prod     = PW'(mag_half) * PW'(rcp);

    always_comb
    begin
        case (digits)
            DIG_M:   q_next = MW'(prod >> (MW + 10));
            DIG_DM:  q_next = MW'(prod >> (MW + 7));
            DIG_CM:  q_next = MW'(prod >> (MW + 4));
            default: q_next = mag_half;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld_r)
        begin
            q_reg   <= q_next;
            neg_reg <= v[COORD_BITS-1];
            dig_reg <= digits;
        end
    end

    always_comb
    begin
        case (dig_reg)
            DIG_M:   step = STEP_W'(1000);
            DIG_DM:  step = STEP_W'(100);
            DIG_CM:  step = STEP_W'(10);
            default: step = STEP_W'(1);
        endcase
    end

    // scale the quotient back and clamp to the signed coordinate range
    assign rprod = q_reg * step;
    assign rmag  = rprod[MW-1:0];
    assign lim   = neg_reg ? HALF_RANGE : (HALF_RANGE - 1'b1);
    assign sat   = (rmag > lim) ? lim : rmag;
    assign rounded_next = neg_reg ? (~sat[COORD_BITS-1:0] + 1'b1) : sat[COORD_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (ctrl.ld_b)
        begin
            rounded_reg <= rounded_next;
        end
    end

    assign rounded = rounded_reg;

endmodule

// ----- src/pab_accum.sv -----
// Cross products, bounds tracking and shoelace sum accumulation.
module pab_accum #(
    parameter int COORD_BITS = 30
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pab_pkg::pab_acc_ctrl_t        ctrl,
    input  logic signed [COORD_BITS-1:0]  rx,
    input  logic signed [COORD_BITS-1:0]  ry,
    output logic [pab_pkg::SUM_W-1:0]     total,
    output logic signed [COORD_BITS-1:0]  min_x,
    output logic signed [COORD_BITS-1:0]  max_x,
    output logic signed [COORD_BITS-1:0]  min_y,
    output logic signed [COORD_BITS-1:0]  max_y
);
    import pab_pkg::*;

    localparam int PRW = 2 * COORD_BITS;

    // polygon state
    logic                         have_reg;
    logic signed [COORD_BITS-1:0] first_x_reg;
    logic signed [COORD_BITS-1:0] first_y_reg;
    logic signed [COORD_BITS-1:0] prev_x_reg;
    logic signed [COORD_BITS-1:0] prev_y_reg;
    logic signed [COORD_BITS-1:0] min_x_seen_reg;
    logic signed [COORD_BITS-1:0] max_x_seen_reg;
    logic signed [COORD_BITS-1:0] min_y_seen_reg;
    logic signed [COORD_BITS-1:0] max_y_seen_reg;
    logic [SUM_W-1:0]             sum_reg;

    logic signed [COORD_BITS-1:0] ex_px;
    logic signed [COORD_BITS-1:0] ex_py;
    logic signed [COORD_BITS-1:0] fx;
    logic signed [COORD_BITS-1:0] fy;
    logic signed [COORD_BITS-1:0] min_x_next;
    logic signed [COORD_BITS-1:0] max_x_next;
    logic signed [COORD_BITS-1:0] min_y_next;
    logic signed [COORD_BITS-1:0] max_y_next;
    logic signed [PRW-1:0]        p1_next;
    logic signed [PRW-1:0]        p2_next;
    logic signed [PRW-1:0]        p3_next;
    logic signed [PRW-1:0]        p4_next;

    // product stage
    logic signed [PRW-1:0]        p1_reg;
    logic signed [PRW-1:0]        p2_reg;
    logic signed [PRW-1:0]        p3_reg;
    logic signed [PRW-1:0]        p4_reg;
    logic signed [COORD_BITS-1:0] c_min_x_reg;
    logic signed [COORD_BITS-1:0] c_max_x_reg;
    logic signed [COORD_BITS-1:0] c_min_y_reg;
    logic signed [COORD_BITS-1:0] c_max_y_reg;

    // term stage
    logic [SUM_W-1:0]             edge_term;
    logic [SUM_W-1:0]             close_term;
    logic [SUM_W-1:0]             term_next;
    logic [SUM_W-1:0]             t_term_reg;
    logic signed [COORD_BITS-1:0] t_min_x_reg;
    logic signed [COORD_BITS-1:0] t_max_x_reg;
    logic signed [COORD_BITS-1:0] t_min_y_reg;
    logic signed [COORD_BITS-1:0] t_max_y_reg;

    // total stage
    logic [SUM_W-1:0]             total_next;
    logic [SUM_W-1:0]             d_total_reg;
    logic signed [COORD_BITS-1:0] d_min_x_reg;
    logic signed [COORD_BITS-1:0] d_max_x_reg;
    logic signed [COORD_BITS-1:0] d_min_y_reg;
    logic signed [COORD_BITS-1:0] d_max_y_reg;

    // first vertex: no edge yet, and the closing edge pairs it with itself
    assign ex_px = have_reg ? prev_x_reg  : '0;
    assign ex_py = have_reg ? prev_y_reg  : '0;
    assign fx    = have_reg ? first_x_reg : rx;
    assign fy    = have_reg ? first_y_reg : ry;

    assign min_x_next = (!have_reg || (rx < min_x_seen_reg)) ? rx : min_x_seen_reg;
    assign max_x_next = (!have_reg || (rx > max_x_seen_reg)) ? rx : max_x_seen_reg;
    assign min_y_next = (!have_reg || (ry < min_y_seen_reg)) ? ry : min_y_seen_reg;
    assign max_y_next = (!have_reg || (ry > max_y_seen_reg)) ? ry : max_y_seen_reg;

    assign p1_next = ex_px * ry;
    assign p2_next = rx * ex_py;
    assign p3_next = rx * fy;
    assign p4_next = fx * ry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
        end
        else if (ctrl.ld_c)
        begin
            have_reg <= !ctrl.b_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld_c)
        begin
            if (!have_reg)
            begin
                first_x_reg <= rx;
                first_y_reg <= ry;
            end
            prev_x_reg     <= rx;
            prev_y_reg     <= ry;
            min_x_seen_reg <= min_x_next;
            max_x_seen_reg <= max_x_next;
            min_y_seen_reg <= min_y_next;
            max_y_seen_reg <= max_y_next;
            p1_reg         <= p1_next;
            p2_reg         <= p2_next;
            p3_reg         <= p3_next;
            p4_reg         <= p4_next;
            c_min_x_reg    <= min_x_next;
            c_max_x_reg    <= max_x_next;
            c_min_y_reg    <= min_y_next;
            c_max_y_reg    <= max_y_next;
        end
    end

    assign edge_term  = SUM_W'(p1_reg) - SUM_W'(p2_reg);
    assign close_term = SUM_W'(p3_reg) - SUM_W'(p4_reg);
    assign term_next  = edge_term + (ctrl.c_last ? close_term : '0);

    always_ff @(posedge clk)
    begin
        if (ctrl.ld_t)
        begin
            t_term_reg  <= term_next;
            t_min_x_reg <= c_min_x_reg;
            t_max_x_reg <= c_max_x_reg;
            t_min_y_reg <= c_min_y_reg;
            t_max_y_reg <= c_max_y_reg;
        end
    end

    assign total_next = sum_reg + t_term_reg;

    // wrap modulo 2^64; drop the sum once the polygon closes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (ctrl.upd_sum)
        begin
            sum_reg <= ctrl.t_last ? '0 : total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld_d)
        begin
            d_total_reg <= total_next;
            d_min_x_reg <= t_min_x_reg;
            d_max_x_reg <= t_max_x_reg;
            d_min_y_reg <= t_min_y_reg;
            d_max_y_reg <= t_max_y_reg;
        end
    end

    assign total = d_total_reg;
    assign min_x = d_min_x_reg;
    assign max_x = d_max_x_reg;
    assign min_y = d_min_y_reg;
    assign max_y = d_max_y_reg;

endmodule

// ----- src/pab_checker.sv -----
// Port-level checks on the result stream of the polygon area and bounds block.
`include "polygon_area_and_bounds_macros.svh"

module pab_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [pab_pkg::OUT_DATA_W-1:0] m_tdata
);
    import pab_pkg::*;

    `PAB_ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result word changed while stalled")
    `PAB_ASSERT_IMPL(a_box_x, m_tvalid, $signed(m_tdata[91:62]) <= $signed(m_tdata[121:92]), "bound_min_x above bound_max_x")
    `PAB_ASSERT_IMPL(a_box_y, m_tvalid, $signed(m_tdata[151:122]) <= $signed(m_tdata[181:152]), "bound_min_y above bound_max_y")
    `PAB_ASSERT_IMPL(a_area_cap, m_tvalid && m_tdata[AREA_W-1], m_tdata[AREA_W-2:0] == '0, "area_doubled beyond its cap")

endmodule

bind polygon_area_and_bounds pab_checker u_pab_checker (.*);
